@@ src/srt_pkg.sv @@
// Shared types and codes for the shortest route table core.
// No dependencies; used by every module of the block.
`default_nettype none

package srt_pkg;

   localparam int unsigned KEY_W  = 16;
   localparam int unsigned HOP_W  = 16;
   localparam int unsigned DIST_W = 32;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [2:0] STAT_REPLACED = 3'd0;
   localparam logic [2:0] STAT_INSERTED = 3'd1;
   localparam logic [2:0] STAT_KEPT     = 3'd2;
   localparam logic [2:0] STAT_FULL     = 3'd3;
   localparam logic [2:0] STAT_MISS     = 3'd4;

   typedef struct packed {
      logic [DIST_W-1:0] metric;
      logic [HOP_W-1:0]  hop;
   } route_type;

endpackage

`default_nettype wire

@@ src/srt_key_scan.sv @@
// Destination key memory with a registered read port and the key compare.
// Depends on srt_pkg.
`default_nettype none

module srt_key_scan #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [IDX_W-1:0]         rd_addr,
   input  wire logic                     wr_en,
   input  wire logic [IDX_W-1:0]         wr_addr,
   input  wire logic [srt_pkg::KEY_W-1:0] wr_key,
   input  wire logic [srt_pkg::KEY_W-1:0] dest,
   output logic                          match
);

   logic [srt_pkg::KEY_W-1:0] key_mem [ENTRIES];
   logic [srt_pkg::KEY_W-1:0] key_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
      end
   end

   assign match = (key_rd_ff == dest);

endmodule

`default_nettype wire

@@ src/srt_route_store.sv @@
// Next hop and distance memory, one write and one registered read per cycle.
// Depends on srt_pkg for the route record.
`default_nettype none

module srt_route_store #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic               clock,
   input  wire logic               rd_en,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output srt_pkg::route_type      rd_data,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire srt_pkg::route_type wr_data
);

   srt_pkg::route_type route_mem [ENTRIES];
   srt_pkg::route_type route_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         route_rd_ff <= route_mem[rd_addr];
      end
   end

   assign rd_data = route_rd_ff;

endmodule

`default_nettype wire

@@ src/shortest_route_table_core.sv @@
// Top level of the shortest route table: sequencer, request and response registers.
// Depends on srt_pkg, srt_key_scan and srt_route_store.
//
//   channel   direction  tdata                                  tuser
//   req       in         dest_id[15:0] next_hop[31:16]          cmd[0]
//                        distance[63:32]
//   rsp       out        hop_out[15:0] dist_out[47:16]          status[2:0] found[3]
//
// A request passes through the scan, decide and response states after acceptance;
// the linear key search, one key memory read per cycle, runs from index 0 until
// the matching key is found or the stored entry count is reached (no key read
// for an empty table).
// Reset empties the table at once; memory contents need no clearing.
// One request is in work at a time; a new request is taken while a response waits.
// A stalled response holds the sequencer in its last state until the slot frees.
`default_nettype none

module shortest_route_table_core #(
   parameter int unsigned ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // dest_id, next_hop, distance
   input  wire logic        req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // hop_out, dist_out
   output logic [3:0]       rsp_tuser    // status, found
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DECIDE = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hidx_ff, hidx_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;

   logic                          cmd_ff;
   logic [srt_pkg::KEY_W-1:0]     dest_ff;
   srt_pkg::route_type            req_route_ff;
   logic [2:0]                    res_status_ff, res_status_in;
   logic                          res_found_ff, res_found_in;
   srt_pkg::route_type            res_route_ff, res_route_in;
   logic [47:0]                   rsp_tdata_ff;
   logic [3:0]                    rsp_tuser_ff;

   logic               accept;
   logic               match;
   logic               hit_now;
   logic               issue;
   logic               out_free;
   logic               load_rsp;
   logic               key_wr_en;
   logic               route_rd_en;
   logic               route_wr_en;
   logic [IDX_W-1:0]   route_wr_addr;
   srt_pkg::route_type route_rd;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign hit_now    = pend_ff && match;
   assign issue      = (state_ff == S_SCAN) && (scan_ff < count_ff) && !hit_now;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   srt_key_scan #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_key_scan (
      .clock   (clock),
      .rd_en   (issue),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .wr_en   (key_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_key  (dest_ff),
      .dest    (dest_ff),
      .match   (match)
   );

   srt_route_store #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_route_store (
      .clock   (clock),
      .rd_en   (route_rd_en),
      .rd_addr (pidx_ff),
      .rd_data (route_rd),
      .wr_en   (route_wr_en),
      .wr_addr (route_wr_addr),
      .wr_data (req_route_ff)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      hidx_in       = hidx_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_route_in  = res_route_ff;
      key_wr_en     = 1'b0;
      route_rd_en   = 1'b0;
      route_wr_en   = 1'b0;
      route_wr_addr = hidx_ff;
      load_rsp      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            pend_in = issue;
            pidx_in = scan_ff[IDX_W-1:0];
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (hit_now) begin
               hit_in      = 1'b1;
               hidx_in     = pidx_ff;
               route_rd_en = 1'b1;
               state_in    = S_DECIDE;
            end else if (!issue && !pend_ff) begin
               hit_in   = 1'b0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            priority if (cmd_ff == srt_pkg::CMD_LOOKUP) begin
               res_status_in = hit_ff ? srt_pkg::STAT_KEPT : srt_pkg::STAT_MISS;
               res_found_in  = hit_ff;
               res_route_in  = hit_ff ? route_rd : '0;
            end else if (hit_ff) begin
               res_found_in = 1'b1;
               if (req_route_ff.metric <= route_rd.metric) begin
                  route_wr_en   = 1'b1;
                  res_status_in = srt_pkg::STAT_REPLACED;
                  res_route_in  = req_route_ff;
               end else begin
                  res_status_in = srt_pkg::STAT_KEPT;
                  res_route_in  = route_rd;
               end
            end else if (count_ff == CNT_W'(ENTRIES)) begin
               res_status_in = srt_pkg::STAT_FULL;
               res_found_in  = 1'b0;
               res_route_in  = '0;
            end else begin
               key_wr_en     = 1'b1;
               route_wr_en   = 1'b1;
               route_wr_addr = count_ff[IDX_W-1:0];
               count_in      = count_ff + CNT_W'(1);
               res_status_in = srt_pkg::STAT_INSERTED;
               res_found_in  = 1'b1;
               res_route_in  = req_route_ff;
            end
         end
         S_RESP: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         pend_ff       <= pend_in;
         hit_ff        <= hit_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff       <= pidx_in;
      hidx_ff       <= hidx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_route_ff  <= res_route_in;
      if (accept) begin
         cmd_ff              <= req_tuser;
         dest_ff             <= req_tdata[15:0];
         req_route_ff.hop    <= req_tdata[31:16];
         req_route_ff.metric <= req_tdata[63:32];
      end
      if (load_rsp) begin
         rsp_tdata_ff <= {res_route_ff.metric, res_route_ff.hop};
         rsp_tuser_ff <= {res_found_ff, res_status_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table depth");

   a_count_only_on_decide: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_DECIDE |=> count_ff == $past(count_ff))
      else $error("entry count changed outside decide");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_ff <= count_ff)
      else $error("scan index passed entry count");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid_ff ##1 rsp_tvalid_ff |-> $past(state_ff == S_RESP))
      else $error("response raised outside response state");

   a_no_write_while_scan: assert property (@(posedge clock) disable iff (reset)
      (key_wr_en || route_wr_en) |-> state_ff == S_DECIDE)
      else $error("memory write outside decide");

endmodule

`default_nettype wire

@@ test/tb_shortest_route_table_core.sv @@
// Testbench for shortest_route_table_core: directed and random route updates and lookups.
// Depends on srt_pkg and the core; a scoreboard class predicts every response in order.
`default_nettype none

module tb_shortest_route_table_core;

   localparam int unsigned TABLE_ENTRIES = 64;
   localparam int unsigned RANDOM_ITEMS  = 600;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = TABLE_ENTRIES + 16;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [2:0]                 status;
      logic                       found;
      logic [srt_pkg::HOP_W-1:0]  hop;
      logic [srt_pkg::DIST_W-1:0] metric;
   } route_reply_type;

   class route_scoreboard;
      logic [srt_pkg::KEY_W-1:0]  key_store [TABLE_ENTRIES];
      logic [srt_pkg::HOP_W-1:0]  hop_store [TABLE_ENTRIES];
      logic [srt_pkg::DIST_W-1:0] dist_store[TABLE_ENTRIES];
      int unsigned                entry_count;
      route_reply_type            replies_due[$];
      int unsigned                mismatches;

      function new();
         entry_count = 0;
         mismatches  = 0;
      endfunction

      function route_reply_type predict_reply(logic cmd,
                                              logic [srt_pkg::KEY_W-1:0] dest,
                                              logic [srt_pkg::HOP_W-1:0] hop,
                                              logic [srt_pkg::DIST_W-1:0] metric);
         route_reply_type reply;
         int              idx;
         idx = -1;
         for (int i = 0; i < int'(entry_count); i++) begin
            if (idx < 0 && key_store[i] == dest) idx = i;
         end
         reply = '{status: srt_pkg::STAT_MISS, found: 1'b0, hop: '0, metric: '0};
         if (cmd == srt_pkg::CMD_LOOKUP) begin
            if (idx >= 0) begin
               reply = '{status: srt_pkg::STAT_KEPT, found: 1'b1,
                         hop: hop_store[idx], metric: dist_store[idx]};
            end
         end else if (idx >= 0) begin
            if (metric <= dist_store[idx]) begin
               hop_store[idx]  = hop;
               dist_store[idx] = metric;
               reply = '{status: srt_pkg::STAT_REPLACED, found: 1'b1,
                         hop: hop, metric: metric};
            end else begin
               reply = '{status: srt_pkg::STAT_KEPT, found: 1'b1,
                         hop: hop_store[idx], metric: dist_store[idx]};
            end
         end else if (entry_count >= TABLE_ENTRIES) begin
            reply.status = srt_pkg::STAT_FULL;
         end else begin
            key_store[entry_count]  = dest;
            hop_store[entry_count]  = hop;
            dist_store[entry_count] = metric;
            entry_count++;
            reply = '{status: srt_pkg::STAT_INSERTED, found: 1'b1,
                      hop: hop, metric: metric};
         end
         return reply;
      endfunction

      function void note_request(logic cmd, logic [srt_pkg::KEY_W-1:0] dest,
                                 logic [srt_pkg::HOP_W-1:0] hop,
                                 logic [srt_pkg::DIST_W-1:0] metric);
         replies_due.push_back(predict_reply(cmd, dest, hop, metric));
      endfunction

      function void check_response(route_reply_type actual);
         route_reply_type want;
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: status %0d found %0d hop %h dist %h",
                        actual.status, actual.found, actual.hop, actual.metric);
            return;
         end
         want = replies_due.pop_front();
         if (actual.status !== want.status || actual.found !== want.found ||
             actual.hop !== want.hop || actual.metric !== want.metric) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"response mismatch: expected status %0d found %0d hop %h dist %h,",
                         " got status %0d found %0d hop %h dist %h"},
                        want.status, want.found, want.hop, want.metric,
                        actual.status, actual.found, actual.hop, actual.metric);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // dest_id, next_hop, distance
   logic        req_tuser  = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // hop_out, dist_out
   logic [3:0]  rsp_tuser;         // status, found

   route_scoreboard sb = new();
   logic            idle_off = 1'b0;
   int unsigned     stall_left = 0;
   int unsigned     cycle_count = 0;

   shortest_route_table_core #(.ENTRIES(TABLE_ENTRIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response('{status: rsp_tuser[2:0], found: rsp_tuser[3],
                             hop: rsp_tdata[15:0], metric: rsp_tdata[47:16]});
      end
      if (idle_off) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         if (stall_left == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left--;
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [srt_pkg::KEY_W-1:0] dest,
                               input logic [srt_pkg::HOP_W-1:0] hop,
                               input logic [srt_pkg::DIST_W-1:0] metric);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {metric, hop, dest};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, dest, hop, metric);
      gap = idle_off ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      logic                       cmd;
      logic [srt_pkg::KEY_W-1:0]  dest;
      logic [srt_pkg::HOP_W-1:0]  hop;
      logic [srt_pkg::DIST_W-1:0] metric;
      logic [31:0]                rnd;
      int unsigned                idx;
      int unsigned                r;
      cmd    = ($urandom_range(0, 99) < 35) ? srt_pkg::CMD_LOOKUP : srt_pkg::CMD_UPDATE;
      rnd    = $urandom;
      hop    = rnd[15:0];
      dest   = rnd[31:16];
      metric = $urandom;
      if (sb.entry_count != 0 && $urandom_range(0, 99) < 60) begin
         idx  = $urandom_range(0, sb.entry_count - 1);
         dest = sb.key_store[idx];
         r    = $urandom_range(0, 3);
         if (r == 0)
            metric = sb.dist_store[idx];
         else if (r == 1)
            metric = sb.dist_store[idx] - $urandom_range(0, 255);
         else if (r == 2)
            metric = sb.dist_store[idx] + $urandom_range(1, 255);
      end
      send_request(cmd, dest, hop, metric);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(srt_pkg::CMD_LOOKUP, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(srt_pkg::CMD_UPDATE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(srt_pkg::CMD_LOOKUP, 16'h0000, 16'h0000, 32'h0000_0000);
      send_request(srt_pkg::CMD_UPDATE, 16'h0000, 16'h1234, 32'hFFFF_FFFF);
      send_request(srt_pkg::CMD_UPDATE, 16'h0000, 16'h0000, 32'h0000_0000);
      send_request(srt_pkg::CMD_UPDATE, 16'h0000, 16'hFFFF, 32'h0000_0001);
      send_request(srt_pkg::CMD_LOOKUP, 16'h0000, 16'h5555, 32'h5555_5555);
      send_request(srt_pkg::CMD_UPDATE, 16'hFFFF, 16'h0000, 32'h0000_0000);
      send_request(srt_pkg::CMD_UPDATE, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
      send_request(srt_pkg::CMD_LOOKUP, 16'hFFFF, 16'hAAAA, 32'hAAAA_AAAA);
      send_request(srt_pkg::CMD_LOOKUP, 16'h5555, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(srt_pkg::CMD_UPDATE, 16'hAAAA, 16'h5555, 32'h0001_0000);
      send_request(srt_pkg::CMD_UPDATE, 16'hAAAA, 16'hAAAA, 32'h0000_FFFF);
      send_request(srt_pkg::CMD_UPDATE, 16'hAAAA, 16'h0001, 32'hFFFF_0000);
      send_request(srt_pkg::CMD_UPDATE, 16'hAAAA, 16'h8000, 32'h0000_FFFF);
      send_request(srt_pkg::CMD_LOOKUP, 16'hAAAA, 16'h0000, 32'h0000_0000);
      send_request(srt_pkg::CMD_UPDATE, 16'h5555, 16'h5555, 32'h8000_0000);
      send_request(srt_pkg::CMD_LOOKUP, 16'h5555, 16'h0000, 32'h0000_0000);
      send_request(srt_pkg::CMD_UPDATE, 16'h8001, 16'h7FFE, 32'h7FFF_FFFF);
      send_request(srt_pkg::CMD_LOOKUP, 16'h8001, 16'hFFFF, 32'hFFFF_FFFF);

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 4) idle_off = 1'b1;
         if (n == RANDOM_ITEMS / 2) begin
            idle_off = 1'b0;
            drain_responses();
         end
         random_request();
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
src/srt_pkg.sv
src/srt_key_scan.sv
src/srt_route_store.sv
src/shortest_route_table_core.sv
test/tb_shortest_route_table_core.sv
